@@ rtl/c3s2g_pkg.sv @@
// Package for the 3x3 stride-2 convolution with GELU: request types, constants, table maths.
`default_nettype none

package c3s2g_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int TAPS       = 9;
    localparam int CH_WIDTH   = 9;
    localparam int FRAC_BITS  = 12;

    // GELU table covers [-4.0, 4.0) in Q3.12
    localparam logic signed [DATA_WIDTH-1:0] GELU_HI = 16'sd16384;
    localparam logic signed [DATA_WIDTH-1:0] GELU_LO = -16'sd16384;

    localparam logic [63:0] INV_SQRT_2PI_Q30 = 64'd428361012;
    localparam int          PHI_TERMS        = 48;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                          operation;
        logic [CH_WIDTH-1:0]          channel;
        logic signed [DATA_WIDTH-1:0] tap_0;
        logic signed [DATA_WIDTH-1:0] tap_1;
        logic signed [DATA_WIDTH-1:0] tap_2;
        logic signed [DATA_WIDTH-1:0] tap_3;
        logic signed [DATA_WIDTH-1:0] tap_4;
        logic signed [DATA_WIDTH-1:0] tap_5;
        logic signed [DATA_WIDTH-1:0] tap_6;
        logic signed [DATA_WIDTH-1:0] tap_7;
        logic signed [DATA_WIDTH-1:0] tap_8;
        logic signed [DATA_WIDTH-1:0] bias_value;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] activation;
        logic [CH_WIDTH-1:0]          out_channel;
    } t_out_req;

    // restoring long division, used only while building the constant table
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], a[k]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // q (Q40) times x2 (Q24), back to Q40
    function automatic logic [63:0] mul_q24(input logic [63:0] q, input logic [63:0] x2);
        return (((q >> 20) * x2) >> 4) + (((q & 64'hFFFFF) * x2) >> 24);
    endfunction

    // GELU(x) = x * Phi(x), Phi from the Taylor series of the normal integral
    function automatic int gelu_point(input int xq);
        logic [63:0]        ax;
        logic [63:0]        x2;
        logic [63:0]        q;
        logic [63:0]        term;
        logic [63:0]        p;
        logic [63:0]        phi;
        logic [63:0]        mag;
        logic signed [63:0] s;
        ax = (xq < 0) ? 64'(-xq) : 64'(xq);
        x2 = (ax * ax) >> 1;
        q  = ax << 28;
        s  = '0;
        for (int n = 0; n < PHI_TERMS; n++) begin
            term = udiv64(q, 64'(2 * n + 1));
            if ((n & 1) != 0) begin
                s = s - $signed(term);
            end else begin
                s = s + $signed(term);
            end
            q = udiv64(mul_q24(q, x2), 64'(n + 1));
        end
        if (s < 0) begin
            s = '0;
        end
        p = (($unsigned(s) >> 16) * INV_SQRT_2PI_Q30) >> 24;
        if (xq >= 0) begin
            phi = (64'd1 << 29) + p;
            if (phi > (64'd1 << 30)) begin
                phi = 64'd1 << 30;
            end
        end else begin
            phi = (p >= (64'd1 << 29)) ? 64'd0 : (64'd1 << 29) - p;
        end
        mag = (ax * phi + (64'd1 << 29)) >> 30;
        return (xq < 0) ? -int'(mag) : int'(mag);
    endfunction

endpackage

`default_nettype wire

@@ rtl/c3s2g_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module c3s2g_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 480,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/conv3x3_stride2_gelu.sv @@
// Top level: 3x3 convolution output with bias, saturation and table GELU.
// A compute request passes stages 1 to 6 in order; the stage 6 register drives the output.
// Throughput: one request (load or compute) per cycle unless o_in_stall is high; the six
// stages compress bubbles; requests enter while a result waits, until every stage is full.
// A load to a channel below CHANNELS writes the kernel RAM in its accept cycle; no result.
// Reset clears the stage valid bits only; kernel and bias RAM are undefined until loaded.
`default_nettype none

module conv3x3_stride2_gelu #(
    parameter int CHANNELS         = 480,
    parameter int GELU_TABLE_DEPTH = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire c3s2g_pkg::t_in_req  i_in_req,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output c3s2g_pkg::t_out_req      o_out_req
);

    import c3s2g_pkg::*;

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW     = (GELU_TABLE_DEPTH > 1) ? $clog2(GELU_TABLE_DEPTH) : 1;
    localparam int WORD_W = (TAPS + 1) * DATA_WIDTH;
    localparam int NSTG   = 6;
    localparam int PW     = 2 * DATA_WIDTH;
    localparam int SW     = PW + 3;
    localparam int AWD    = PW + 4;
    localparam int MW     = 16 + IW;

    // ---------------- GELU constant table ----------------
    logic signed [DATA_WIDTH-1:0] gelu_tab [GELU_TABLE_DEPTH];

    for (genvar gi = 0; gi < GELU_TABLE_DEPTH; gi++) begin : g_tab
        localparam int XQ = -16384 + (gi * 32768) / GELU_TABLE_DEPTH;
        localparam int GV = gelu_point(XQ);
        assign gelu_tab[gi] = DATA_WIDTH'(GV);
    end

    // ---------------- handshake ----------------
    logic [NSTG:1] r_v;
    logic [NSTG+1:1] rdy;
    logic          in_acc;
    logic          in_inr;

    always_comb begin
        rdy[NSTG+1] = !i_out_stall;
        for (int k = NSTG; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_in_stall = !rdy[1];
    assign in_acc     = i_in_valid && rdy[1];
    assign in_inr     = 32'(i_in_req.channel) < CHANNELS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_in_valid && (i_in_req.operation == OP_COMPUTE);
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- kernel RAM: {bias, tap_8 .. tap_0} per channel ----------------
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    assign ram_addr  = AW'(i_in_req.channel);
    assign ram_we    = in_acc && (i_in_req.operation == OP_LOAD) && in_inr;
    assign ram_re    = in_acc && (i_in_req.operation == OP_COMPUTE);
    assign ram_wdata = {i_in_req.bias_value, i_in_req.tap_8, i_in_req.tap_7, i_in_req.tap_6,
                        i_in_req.tap_5, i_in_req.tap_4, i_in_req.tap_3, i_in_req.tap_2,
                        i_in_req.tap_1, i_in_req.tap_0};

    c3s2g_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_kram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------- stage 1: window held, kernel word arrives ----------------
    logic signed [DATA_WIDTH-1:0] r1_tap [TAPS];
    logic [CH_WIDTH-1:0]          r1_ch;
    logic                         r1_inr;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_tap[0] <= i_in_req.tap_0;
            r1_tap[1] <= i_in_req.tap_1;
            r1_tap[2] <= i_in_req.tap_2;
            r1_tap[3] <= i_in_req.tap_3;
            r1_tap[4] <= i_in_req.tap_4;
            r1_tap[5] <= i_in_req.tap_5;
            r1_tap[6] <= i_in_req.tap_6;
            r1_tap[7] <= i_in_req.tap_7;
            r1_tap[8] <= i_in_req.tap_8;
            r1_ch     <= i_in_req.channel;
            r1_inr    <= in_inr;
        end
    end

    // ---------------- stage 2: nine products ----------------
    logic signed [DATA_WIDTH-1:0] w [TAPS];
    logic signed [PW-1:0]         n_prod [TAPS];
    logic signed [PW-1:0]         r2_prod [TAPS];
    logic signed [DATA_WIDTH-1:0] r2_bias;
    logic [CH_WIDTH-1:0]          r2_ch;
    logic                         r2_inr;

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            w[k]      = ram_rdata[k*DATA_WIDTH +: DATA_WIDTH];
            n_prod[k] = r1_tap[k] * w[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_prod <= n_prod;
            r2_bias <= ram_rdata[TAPS*DATA_WIDTH +: DATA_WIDTH];
            r2_ch   <= r1_ch;
            r2_inr  <= r1_inr;
        end
    end

    // ---------------- stage 3: two partial sums, bias and rounding folded in ----------------
    logic signed [SW-1:0] n_pa;
    logic signed [SW-1:0] n_pb;
    logic signed [SW-1:0] r3_pa;
    logic signed [SW-1:0] r3_pb;
    logic [CH_WIDTH-1:0]  r3_ch;
    logic                 r3_inr;
    logic signed [DATA_WIDTH+FRAC_BITS-1:0] bias_sh;

    always_comb begin
        bias_sh = $signed({r2_bias, {FRAC_BITS{1'b0}}});
        n_pa = SW'(r2_prod[0]) + SW'(r2_prod[1]) + SW'(r2_prod[2])
             + SW'(r2_prod[3]) + SW'(r2_prod[4]);
        n_pb = SW'(r2_prod[5]) + SW'(r2_prod[6]) + SW'(r2_prod[7])
             + SW'(r2_prod[8]) + SW'(bias_sh) + SW'(2048);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_pa  <= n_pa;
            r3_pb  <= n_pb;
            r3_ch  <= r2_ch;
            r3_inr <= r2_inr;
        end
    end

    // ---------------- stage 4: final add, floor shift, saturate ----------------
    logic signed [AWD-1:0]           n_acc;
    logic signed [AWD-FRAC_BITS-1:0] n_sh;
    logic signed [DATA_WIDTH-1:0]    n_sum;
    logic signed [DATA_WIDTH-1:0]    r4_sum;
    logic [CH_WIDTH-1:0]             r4_ch;
    logic                            r4_inr;

    always_comb begin
        n_acc = AWD'(r3_pa) + AWD'(r3_pb);
        n_sh  = n_acc[AWD-1:FRAC_BITS];
        priority if (n_sh > (AWD-FRAC_BITS)'(32767)) begin
            n_sum = 16'sd32767;
        end else if (n_sh < -(AWD-FRAC_BITS)'(32768)) begin
            n_sum = -16'sd32768;
        end else begin
            n_sum = n_sh[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_sum <= n_sum;
            r4_ch  <= r3_ch;
            r4_inr <= r3_inr;
        end
    end

    // ---------------- stage 5: table index and range flags ----------------
    logic [DATA_WIDTH-1:0]        off;
    logic [MW-1:0]                n_mul;
    logic [IW-1:0]                r5_idx;
    logic                         r5_low;
    logic                         r5_high;
    logic signed [DATA_WIDTH-1:0] r5_sum;
    logic [CH_WIDTH-1:0]          r5_ch;
    logic                         r5_inr;

    always_comb begin
        off   = r4_sum - GELU_LO;
        n_mul = MW'(off[14:0]) * MW'(GELU_TABLE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_idx  <= n_mul[15 +: IW];
            r5_low  <= r4_sum < GELU_LO;
            r5_high <= r4_sum >= GELU_HI;
            r5_sum  <= r4_sum;
            r5_ch   <= r4_ch;
            r5_inr  <= r4_inr;
        end
    end

    // ---------------- stage 6: table lookup, range select, output register ----------------
    logic signed [DATA_WIDTH-1:0] n_act;
    logic signed [DATA_WIDTH-1:0] r6_act;
    logic [CH_WIDTH-1:0]          r6_ch;

    always_comb begin
        priority if (!r5_inr || r5_low) begin
            n_act = '0;
        end else if (r5_high) begin
            n_act = r5_sum;
        end else begin
            n_act = gelu_tab[r5_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r6_act <= n_act;
            r6_ch  <= r5_ch;
        end
    end

    assign o_out_valid           = r_v[NSTG];
    assign o_out_req.activation  = r6_act;
    assign o_out_req.out_channel = r6_ch;

    // ---------------- assertions ----------------
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_v) && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_compute_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_req.operation == OP_COMPUTE) |=> r_v[1])
        else $error("accepted compute request lost at stage 1");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_req.operation == OP_LOAD) |=> !r_v[1])
        else $error("load request entered the result pipeline");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG] && i_out_stall) |=> (r_v[NSTG] && $stable(r6_act) && $stable(r6_ch)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
